@@ rtl/pis_pkg.sv @@
`default_nettype none

package pis_pkg;

  localparam int unsigned MAX_COUNT      = 255;
  localparam int unsigned PROB_FRAC_BITS = 48;

  localparam int unsigned RATE_W  = 16;
  localparam int unsigned UNI_W   = 32;
  localparam int unsigned RATE_FB = 11;
  localparam int unsigned NUM_C   = 16;
  localparam int unsigned DVD_W   = 64 + RATE_W - RATE_FB;
  localparam int unsigned DBIT_W  = $clog2(DVD_W + 1);

  typedef logic [63:0] ctab_t [NUM_C];

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b) + (128'(1) << 61);
    return prod[125:62];
  endfunction

  function automatic logic [63:0] exp_neg_pow2(int unsigned sh);
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    logic        stop;
    t    = 64'(1) << 62;
    pos  = t;
    neg  = '0;
    stop = 1'b0;
    for (int unsigned n = 1; n < 64; n++) begin
      if (!stop) begin
        t = (t >> sh) / 64'(n);
        if (t == '0) begin
          stop = 1'b1;
        end else if (n % 2 == 1) begin
          neg = neg + t;
        end else begin
          pos = pos + t;
        end
      end
    end
    return pos - neg;
  endfunction

  function automatic ctab_t build_ctab();
    ctab_t c;
    for (int unsigned k = 0; k < 12; k++) begin
      c[k] = exp_neg_pow2(11 - k);
    end
    for (int unsigned k = 12; k < NUM_C; k++) begin
      c[k] = mul_q62(c[k-1], c[k-1]);
    end
    return c;
  endfunction

  localparam ctab_t C_TAB = build_ctab();

  typedef struct packed {
    logic load;
    logic k_inc;
    logic acc_clr;
    logic mul_p;
    logic mul_step;
    logic e_round;
    logic p_init;
    logic cnt_inc;
    logic div_init;
    logic div_step;
    logic p_update;
    logic out_load;
    logic out_sat;
  } pis_cmd_t;

  typedef struct packed {
    logic k_done;
    logic rate_bit;
    logic part_last;
    logic div_last;
    logic at_least;
    logic cnt_max;
  } pis_stat_t;

endpackage

`default_nettype wire

@@ rtl/pis_datapath.sv @@
`default_nettype none

module pis_datapath #(
  parameter int unsigned MaxCount     = pis_pkg::MAX_COUNT,
  parameter int unsigned ProbFracBits = pis_pkg::PROB_FRAC_BITS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire pis_pkg::pis_cmd_t          cmd_i,
  output pis_pkg::pis_stat_t              stat_o,
  input  wire logic [pis_pkg::RATE_W-1:0] rate_i,
  input  wire logic [pis_pkg::UNI_W-1:0]  uniform_i,
  output logic [7:0]                      count_o,
  output logic                            saturated_o
);
  import pis_pkg::*;

  localparam int unsigned CntW = $clog2(MaxCount + 1);
  localparam int unsigned Sh   = 62 - ProbFracBits;
  localparam logic [64:0] Rnd  = (Sh > 0) ? (65'(1) << (Sh - 1)) : 65'(0);

  logic [RATE_W-1:0] rate_q;
  logic [UNI_W-1:0]  uni_q;
  logic [4:0]        k_q, k_d;
  logic [63:0]       e_q, e_d;
  logic [63:0]       p_q, p_d;
  logic [63:0]       cdf_q, cdf_d;
  logic [127:0]      acc_q, acc_d;
  logic [1:0]        part_q, part_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DBIT_W-1:0] dbit_q, dbit_d;
  logic [7:0]        cnt_out_q;
  logic              sat_out_q;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic [127:0] prod_sh;
  logic [127:0] rnd_acc;
  logic [64:0]  e_rnd;
  logic [CntW:0] rem_sh;
  logic          q_bit;
  logic [64:0]   cdf_sum;
  logic [95:0]   u_ext, cdf_ext;

  always_comb begin
    if (cmd_i.mul_p) begin
      mul_a   = part_q[0] ? p_q[63:32] : p_q[31:0];
      mul_b   = 32'(rate_q);
      prod    = 64'(mul_a) * 64'(mul_b);
      prod_sh = part_q[0] ? (128'(prod) << 32) : 128'(prod);
    end else begin
      mul_a   = part_q[0] ? e_q[63:32] : e_q[31:0];
      mul_b   = part_q[1] ? C_TAB[k_q[3:0]][63:32] : C_TAB[k_q[3:0]][31:0];
      prod    = 64'(mul_a) * 64'(mul_b);
      prod_sh = 128'(prod) << (32 * (32'(part_q[0]) + 32'(part_q[1])));
    end
    rnd_acc = acc_q + (128'(1) << 61);
    e_rnd   = 65'(e_q) + Rnd;
    rem_sh  = {rem_q, dvd_q[DVD_W-1]};
    q_bit   = rem_sh >= {1'b0, count_q};
    cdf_sum = 65'(cdf_q) + 65'(dvd_q[63:0]);
    u_ext   = 96'(uni_q) << ProbFracBits;
    cdf_ext = 96'(cdf_q) << 32;
  end

  always_comb begin
    k_d     = k_q;
    e_d     = e_q;
    p_d     = p_q;
    cdf_d   = cdf_q;
    acc_d   = acc_q;
    part_d  = part_q;
    count_d = count_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    dbit_d  = dbit_q;
    if (cmd_i.load) begin
      k_d     = '0;
      e_d     = 64'(1) << 62;
      count_d = '0;
    end
    if (cmd_i.k_inc) begin
      k_d = k_q + 5'd1;
    end
    if (cmd_i.acc_clr) begin
      acc_d  = '0;
      part_d = '0;
    end
    if (cmd_i.mul_step) begin
      acc_d  = acc_q + prod_sh;
      part_d = part_q + 2'd1;
    end
    if (cmd_i.e_round) begin
      e_d = rnd_acc[125:62];
    end
    if (cmd_i.p_init) begin
      p_d   = 64'(e_rnd >> Sh);
      cdf_d = 64'(e_rnd >> Sh);
    end
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.div_init) begin
      rem_d  = '0;
      dvd_d  = acc_q[RATE_FB+DVD_W-1:RATE_FB];
      dbit_d = DBIT_W'(DVD_W);
    end
    if (cmd_i.div_step) begin
      rem_d  = q_bit ? CntW'(rem_sh - {1'b0, count_q}) : rem_sh[CntW-1:0];
      dvd_d  = {dvd_q[DVD_W-2:0], q_bit};
      dbit_d = dbit_q - DBIT_W'(1);
    end
    if (cmd_i.p_update) begin
      p_d   = (|dvd_q[DVD_W-1:64]) ? '1 : dvd_q[63:0];
      cdf_d = cdf_sum[64] ? '1 : cdf_sum[63:0];
      if (|dvd_q[DVD_W-1:64]) begin
        cdf_d = '1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      part_q  <= '0;
      count_q <= '0;
      dbit_q  <= '0;
    end else begin
      k_q     <= k_d;
      part_q  <= part_d;
      count_q <= count_d;
      dbit_q  <= dbit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rate_q <= rate_i;
      uni_q  <= uniform_i;
    end
    e_q   <= e_d;
    p_q   <= p_d;
    cdf_q <= cdf_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (cmd_i.out_load) begin
      cnt_out_q <= 8'(count_q);
      sat_out_q <= cmd_i.out_sat;
    end
  end

  assign stat_o.k_done    = (k_q == 5'(NUM_C));
  assign stat_o.rate_bit  = rate_q[k_q[3:0]];
  assign stat_o.part_last = cmd_i.mul_p ? (part_q == 2'd1) : (part_q == 2'd3);
  assign stat_o.div_last  = (dbit_q == DBIT_W'(1));
  assign stat_o.at_least  = (u_ext >= cdf_ext);
  assign stat_o.cnt_max   = (count_q >= CntW'(MaxCount));
  assign count_o          = cnt_out_q;
  assign saturated_o      = sat_out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxCount))
    else $error("count exceeds its limit");
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < count_q))
    else $error("divider remainder not below divisor");
  a_p_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.p_init |=> (cdf_q == p_q))
    else $error("cdf and p differ after start");
`endif

endmodule

`default_nettype wire

@@ rtl/pis_ctrl.sv @@
`default_nettype none

module pis_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire pis_pkg::pis_stat_t stat_i,
  output pis_pkg::pis_cmd_t       cmd_o
);
  import pis_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_EXP_CHK = 10'b0000000010,
    S_EXP_MUL = 10'b0000000100,
    S_EXP_RND = 10'b0000001000,
    S_PINIT   = 10'b0000010000,
    S_TEST    = 10'b0000100000,
    S_PMUL    = 10'b0001000000,
    S_DIVINIT = 10'b0010000000,
    S_DIV     = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   sat_q, sat_d;
  logic   out_free;
  logic   upd_pending_q, upd_pending_d;

  assign out_free    = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    sat_d   = sat_q;
    cmd_o   = '0;
    ovalid_d = ovalid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (stat_i.k_done) begin
          state_d = S_PINIT;
        end else if (stat_i.rate_bit) begin
          cmd_o.acc_clr = 1'b1;
          state_d       = S_EXP_MUL;
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end
      S_EXP_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.part_last) begin
          state_d = S_EXP_RND;
        end
      end
      S_EXP_RND: begin
        cmd_o.e_round = 1'b1;
        cmd_o.k_inc   = 1'b1;
        state_d       = S_EXP_CHK;
      end
      S_PINIT: begin
        cmd_o.p_init = 1'b1;
        state_d      = S_TEST;
      end
      S_TEST: begin
        if (!stat_i.at_least) begin
          sat_d   = 1'b0;
          state_d = S_DONE;
        end else if (stat_i.cnt_max) begin
          sat_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          cmd_o.acc_clr = 1'b1;
          state_d       = S_PMUL;
        end
      end
      S_PMUL: begin
        cmd_o.mul_p    = 1'b1;
        cmd_o.mul_step = 1'b1;
        if (stat_i.part_last) begin
          state_d = S_DIVINIT;
        end
      end
      S_DIVINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_TEST;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sat  = sat_q;
          ovalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (state_q == S_TEST && upd_pending_q) begin
      cmd_o          = '0;
      cmd_o.p_update = 1'b1;
      state_d        = S_TEST;
    end
  end

  assign upd_pending_d = (state_q == S_DIV) && stat_i.div_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ovalid_q      <= 1'b0;
      sat_q         <= 1'b0;
      upd_pending_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      ovalid_q      <= ovalid_d;
      sat_q         <= sat_d;
      upd_pending_q <= upd_pending_d;
    end
  end

`ifndef SYNTHESIS
  a_out_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside completion");
  a_upd_follows_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_pending_q |-> (state_q == S_TEST))
    else $error("update not in test state");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_EXP_CHK))
    else $error("load did not start exponent");
`endif

endmodule

`default_nettype wire

@@ rtl/poisson_inversion_sampler.sv @@
// Channel  | Dir | Payload
// s_axis   | in  | tdata[15:0] rate, tdata[47:16] uniform_sample
// m_axis   | out | tdata[7:0] count, tuser[0] saturated
// One request at a time; tready is high only while the controller idles.
// Exponent: scans the 16 rate bits and multiplies for each set bit (32x32 multiplier).
// Each count step runs the bit-serial 69-bit divider.
// Reset clears control state and datapath counters only; a held result does not block a new request.
`default_nettype none

module poisson_inversion_sampler #(
  parameter int unsigned MaxCount     = pis_pkg::MAX_COUNT,
  parameter int unsigned ProbFracBits = pis_pkg::PROB_FRAC_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // rate, uniform_sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // count
  output logic             m_axis_tuser    // saturated
);
  import pis_pkg::*;

  pis_cmd_t  cmd;
  pis_stat_t stat;

  pis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pis_datapath #(
    .MaxCount     (MaxCount),
    .ProbFracBits (ProbFracBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rate_i      (s_axis_tdata[15:0]),
    .uniform_i   (s_axis_tdata[47:16]),
    .count_o     (m_axis_tdata),
    .saturated_o (m_axis_tuser)
  );

endmodule

`default_nettype wire
